[src/unsd_pkg.sv]
package unsd_pkg;

	// Control that travels alongside each item through the divider pipeline.
	typedef struct packed {
		logic valid;
		logic zero_div;
	} ctl_t;

endpackage

[src/unsd_step.sv]
module unsd_step #(
	parameter int DATA_WIDTH = 32
) (
	input  logic [DATA_WIDTH-1:0] rem_in,
	input  logic [DATA_WIDTH-1:0] quo_in,
	input  logic [DATA_WIDTH-1:0] div_in,
	input  unsd_pkg::ctl_t        ctl_in,
	output logic [DATA_WIDTH-1:0] rem_out,
	output logic [DATA_WIDTH-1:0] quo_out,
	output logic [DATA_WIDTH-1:0] div_out,
	output unsd_pkg::ctl_t        ctl_out
);

	// One restoring step: shift the next dividend bit into the partial remainder,
	// try a subtract, and shift the quotient bit into the vacated low end.
	logic [DATA_WIDTH:0]   shifted;
	logic [DATA_WIDTH+1:0] diff;
	logic                  fits;

	assign shifted = {rem_in, quo_in[DATA_WIDTH-1]};
	assign diff    = {1'b0, shifted} - {2'b00, div_in};
	assign fits    = ~diff[DATA_WIDTH+1];

	assign rem_out = fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
	assign quo_out = {quo_in[DATA_WIDTH-2:0], fits};
	assign div_out = div_in;
	assign ctl_out = ctl_in;

endmodule

[src/unsigned_divider_32_top.sv]
// Unsigned integer divider, fully pipelined with one quotient bit per stage.
//
// Input channel: dividend and divisor move on a transfer when in_valid and
// in_ready are both high. Output channel: quotient and remainder move on a
// transfer when out_valid and out_ready are both high.
//
// The pipeline has DATA_WIDTH restoring-subtract stages. The input transfer
// loads stage 1, the item then moves on through stages 2 to DATA_WIDTH, and
// the result is driven onto the output from the last stage's registers.
// Throughput is one item per cycle while the receiver keeps out_ready high.
//
// A zero divisor yields a quotient of zero and a remainder equal to the
// dividend. Reset clears only the stage control bits, so the pipeline comes up
// empty and ready to take an item in the first cycle after reset.
//
// When the receiver stalls with a result waiting, the whole pipeline freezes:
// in_ready drops, every stage holds, and nothing is lost or repeated. A bubble
// at the output lets the pipeline advance even while out_ready is low.
module unsigned_divider_32_top #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DATA_WIDTH-1:0] divisor,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_WIDTH-1:0] quotient,
	output logic [DATA_WIDTH-1:0] remainder
);

	// Stage k holds the state after k quotient bits have been decided. The
	// quotient register starts as the dividend and fills with quotient bits
	// from the low end as dividend bits leave from the top.
	logic [DATA_WIDTH-1:0] rem_s [1:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] quo_s [1:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] div_s [1:DATA_WIDTH];
	unsd_pkg::ctl_t        ctl_s [1:DATA_WIDTH];

	// The pipeline moves as one; it may move whenever the last stage is empty
	// or its result is being taken in this cycle.
	logic advance;

	assign advance  = ~ctl_s[DATA_WIDTH].valid | out_ready;
	assign in_ready = advance;

	for (genvar k = 1; k <= DATA_WIDTH; k++) begin : g_stage
		logic [DATA_WIDTH-1:0] rem_in, quo_in, div_in;
		logic [DATA_WIDTH-1:0] rem_nx, quo_nx, div_nx;
		unsd_pkg::ctl_t        ctl_in, ctl_nx;

		if (k == 1) begin : g_first
			assign rem_in          = '0;
			assign quo_in          = dividend;
			assign div_in          = divisor;
			assign ctl_in.valid    = in_valid;
			assign ctl_in.zero_div = (divisor == '0);
		end else begin : g_rest
			assign rem_in = rem_s[k-1];
			assign quo_in = quo_s[k-1];
			assign div_in = div_s[k-1];
			assign ctl_in = ctl_s[k-1];
		end

		unsd_step #(
			.DATA_WIDTH(DATA_WIDTH)
		) u_step (
			.rem_in  (rem_in),
			.quo_in  (quo_in),
			.div_in  (div_in),
			.ctl_in  (ctl_in),
			.rem_out (rem_nx),
			.quo_out (quo_nx),
			.div_out (div_nx),
			.ctl_out (ctl_nx)
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else if (advance) begin
				ctl_s[k] <= ctl_nx;
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				rem_s[k] <= rem_nx;
				quo_s[k] <= quo_nx;
				div_s[k] <= div_nx;
			end
		end
	end

	// With a zero divisor every step "fits", so the raw quotient is all ones
	// and the remainder is the dividend; only the quotient needs forcing.
	assign out_valid = ctl_s[DATA_WIDTH].valid;
	assign quotient  = ctl_s[DATA_WIDTH].zero_div ? '0 : quo_s[DATA_WIDTH];
	assign remainder = rem_s[DATA_WIDTH];

endmodule

[src/unsd_checker.sv]
module unsd_checker #(
	parameter int DATA_WIDTH = 32
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic [DATA_WIDTH-1:0] dividend,
	input logic [DATA_WIDTH-1:0] divisor,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [DATA_WIDTH-1:0] quotient,
	input logic [DATA_WIDTH-1:0] remainder
);

	localparam int CW = $clog2(DATA_WIDTH + 2) + 1;

	// Items taken in but not yet delivered.
	logic [CW-1:0] occ_q;
	logic          in_xfer, out_xfer;

	assign in_xfer  = in_valid & in_ready;
	assign out_xfer = out_valid & out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + CW'(in_xfer) - CW'(out_xfer);
		end
	end

	// A stalled result holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(quotient) && $stable(remainder))
		else $error("result changed while stalled");

	// The input side is held back only by a waiting, untaken result.
	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow output backpressure");

	// No result appears without an item in flight.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> occ_q != '0)
		else $error("result shown with no item in flight");

	// The pipeline never holds more items than it has stages.
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(DATA_WIDTH))
		else $error("more items in flight than pipeline stages");

endmodule

bind unsigned_divider_32_top unsd_checker #(.DATA_WIDTH(DATA_WIDTH)) u_unsd_checker (.*);

[tb/tb.sv]
`timescale 1ns / 100ps

// Self-checking bench for the 32-bit unsigned divider.
//
// A sender drives dividend/divisor transfers on the input channel, and every
// accepted transfer has its quotient and remainder worked out right away by a
// bit-serial restoring division written here. Those predictions queue up in
// order. A monitor on the output channel pops the oldest prediction for each
// result transfer and compares both fields. The receiver side stalls at random
// so that backpressure hits the pipeline at every fill level.
module tb;

	localparam int DATA_WIDTH = 32;
	localparam int HALF_PERIOD = 6;
	localparam int RESET_CYCLES = 9;
	// The slowest legal run is roughly 1700 items, each slowed by the longest idle
	// burst and stall, plus the pipeline drains. This limit is several times that.
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = DATA_WIDTH + 8;

	typedef logic [DATA_WIDTH-1:0] word_t;

	typedef struct packed {
		word_t quotient;
		word_t remainder;
	} division_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	word_t dividend = '0;
	word_t divisor = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	word_t quotient;
	word_t remainder;

	// Predicted results, oldest first, one per accepted input transfer.
	division_t pending_divisions[$];
	int error_count = 0;
	int cycle_count = 0;
	// When low, neither side inserts idle cycles or stalls.
	bit idle_en = 1'b1;

	unsigned_divider_32_top #(
		.DATA_WIDTH(DATA_WIDTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.dividend(dividend),
		.divisor(divisor),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.quotient(quotient),
		.remainder(remainder)
	);

	always #HALF_PERIOD clk = ~clk;

	// Restoring division, one quotient bit per step from the top bit down. The
	// partial remainder gets one extra bit so the shift never loses a carry.
	// A zero divisor gives a zero quotient and hands the dividend back as the
	// remainder.
	function automatic division_t predict_division(word_t num, word_t den);
		division_t res;
		logic [DATA_WIDTH:0] partial;
		res.quotient = '0;
		res.remainder = num;
		partial = '0;
		if (den != '0) begin
			for (int i = DATA_WIDTH - 1; i >= 0; i--) begin
				partial = {partial[DATA_WIDTH-1:0], num[i]};
				res.quotient = res.quotient << 1;
				if (partial >= {1'b0, den}) begin
					partial = partial - {1'b0, den};
					res.quotient[0] = 1'b1;
				end
			end
			res.remainder = partial[DATA_WIDTH-1:0];
		end
		return res;
	endfunction

	// Called at a falling edge, and returns at the falling edge that follows
	// the transfer. An idle burst, if any, comes before the item is presented.
	// Once valid is raised it stays up with a steady payload until the transfer.
	task automatic send_item(input word_t num, input word_t den);
		int gap;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		dividend <= num;
		divisor <= den;
		do @(posedge clk); while (!in_ready);
		pending_divisions.push_back(predict_division(num, den));
		@(negedge clk);
	endtask

	// Takes valid down and holds off until every predicted result has come
	// back. Called at a falling edge and returns at one.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (pending_divisions.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// Operand with a random number of leading zeros, so that small, medium and
	// full-width values all turn up often.
	function automatic word_t random_operand();
		word_t value;
		value = $urandom;
		return value >> $urandom_range(0, DATA_WIDTH - 1);
	endfunction

	// Corner values of both operands, including the all-ones dividend that
	// would overflow a naive repeated-subtraction scheme.
	task automatic test_operand_extremes();
		send_item('0, '0);
		send_item('0, 32'd1);
		send_item('1, 32'd1);
		send_item('1, '1);
		send_item('1, '1 - 32'd1);
		send_item(32'd1, '1);
		send_item('0, '1);
		send_item(32'h8000_0000, 32'h8000_0000);
		send_item(32'h8000_0000, 32'h7FFF_FFFF);
		send_item(32'h7FFF_FFFF, 32'h8000_0000);
		send_item(32'hAAAA_AAAA, 32'h5555_5555);
		send_item(32'h5555_5555, 32'hAAAA_AAAA);
		send_item('1, 32'd3);
	endtask

	// A zero divisor must return a zero quotient and the dividend unchanged.
	task automatic test_zero_divisor();
		send_item(32'd1, '0);
		send_item('1, '0);
		send_item($urandom, '0);
	endtask

	// Power-of-two divisors reduce to shifts but must match plain division.
	task automatic test_power_of_two_divisor();
		send_item('1, 32'd1 << 1);
		send_item('1, 32'd1 << 15);
		send_item('1, 32'd1 << 31);
		send_item($urandom, 32'd1 << $urandom_range(0, 31));
		send_item($urandom, 32'd1 << $urandom_range(0, 31));
		send_item(32'h8000_0000, 32'd1 << 4);
	endtask

	// Fills the pipeline part way, then lets it run completely dry before more
	// traffic arrives. This checks that the last item out of a busy pipe is
	// not held back and that a cold pipe restarts cleanly.
	task automatic test_pipeline_drain();
		for (int round = 0; round < 3; round++) begin
			for (int n = 0; n < 10 + 10 * round; n++) send_item($urandom, random_operand());
			wait_for_results();
		end
	endtask

	// Mixed operand classes. Every few blocks both sides stop idling so that
	// the pipeline also runs at full rate under random content.
	task automatic test_random_operands();
		word_t num;
		word_t den;
		for (int block = 0; block < 6; block++) begin
			idle_en = (block % 3) != 2;
			for (int n = 0; n < 250; n++) begin
				num = $urandom;
				case ($urandom_range(0, 9))
					0: den = '0;
					1: den = 32'd1 << $urandom_range(0, 31);
					2: den = $urandom_range(1, 15);
					3: begin
						// Divisor within two of the dividend (mod 2^32), quotient mostly 0 or 1.
						den = num + $urandom_range(0, 4) - 32'd2;
					end
					4: begin
						num = random_operand();
						den = random_operand();
					end
					5: den = '1 - $urandom_range(0, 3);
					default: den = $urandom;
				endcase
				send_item(num, den);
			end
		end
		idle_en = 1'b1;
	endtask

	// Closing stretch, no idling on either side: one transfer per cycle while ready.
	task automatic test_full_rate();
		idle_en = 1'b0;
		for (int n = 0; n < 150; n++) send_item($urandom, random_operand());
		in_valid <= 1'b0;
	endtask

	// Receiver: the ready line holds high, except for random stall bursts while
	// idling is allowed.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idle_en && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(1, 7);
				out_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Output monitor. Every result transfer is matched against the oldest
	// prediction; a transfer with nothing queued is an error in its own right.
	always @(posedge clk) begin
		division_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_divisions.size() == 0) begin
				$display("%0t: unexpected result: quotient %h remainder %h",
					$time, quotient, remainder);
				error_count++;
			end else begin
				want = pending_divisions.pop_front();
				if (quotient !== want.quotient) begin
					$display("%0t: quotient mismatch: expected %h actual %h",
						$time, want.quotient, quotient);
					error_count++;
				end
				if (remainder !== want.remainder) begin
					$display("%0t: remainder mismatch: expected %h actual %h",
						$time, want.remainder, remainder);
					error_count++;
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("unsigned_divider_32_top regression: fail");
		$finish;
	end

	// Test sequence. Reset is held low at the start and released on a falling
	// edge so that the first transfer lines up with the drive phase.
	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_operand_extremes();
		test_zero_divisor();
		test_power_of_two_divisor();
		test_pipeline_drain();
		test_random_operands();
		test_full_rate();

		// Let the pipeline empty out, then give it a little longer so that a
		// stray extra result would still be caught.
		while (pending_divisions.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0) begin
			$display("unsigned_divider_32_top regression: pass");
		end else begin
			$display("unsigned_divider_32_top regression: fail");
		end
		$finish;
	end

endmodule
